### design/rmmwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmmwf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int DIM_W   = 11;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
	localparam int CH_W    = 8;
	localparam int PIX_W   = 3 * CH_W;
	localparam int STORE_W = 2 * PIX_W;
	localparam int ADDR_W  = 4;

	localparam logic [CH_W-1:0] CH_MAX = CH_W'(255);

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_IMAGE_WIDTH  = 2'd0;
	localparam reg_idx_t REG_IMAGE_HEIGHT = 2'd1;
	localparam reg_idx_t REG_TAKE_MAXIMUM = 2'd2;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic emit;
		logic last;
		logic up_ok;
		logic dn_ok;
		logic lf_ok;
		logic rt_ok;
	} win_ctrl_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] top);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > top) begin
			r = top;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/rgb_min_max_window_filter_3x3.sv
`timescale 1ns / 1ps
`default_nettype none

// 3x3 per-channel erosion (take_maximum = 0, window minimum) or dilation
// (take_maximum = 1, window maximum) of an RGB raster stream; neighbours outside
// the image are left out. One item is taken every clock while the output side
// keeps up. The result for pixel k is produced by the item at raster position
// k + width + 1 and leaves two register stages later (line store read, then
// result register), so after the last pixel the host sends width + 1 flush
// items (tuser = 1); a flush at position zero is dropped. The two line stores
// share one 1024 x 48 RAM with one write and one registered read per clock,
// which sets the one-item-per-clock rate; no clearing pass is needed after
// reset. tlast marks the last result of the image. Change width, height and
// mode only while no item is in flight; a change inside an image carries on
// from the current raster position, and a centre past the end of the image
// gives no result and returns the position to zero.
module rgb_min_max_window_filter_3x3
	import rmmwf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              s_axis_tvalid,
	output      logic              s_axis_tready,
	input  wire logic [PIX_W-1:0]  s_axis_tdata,  // red_in, green_in, blue_in
	input  wire logic              s_axis_tuser,  // kind

	output      logic              m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output      logic [PIX_W-1:0]  m_axis_tdata,  // red_out, green_out, blue_out
	output      logic              m_axis_tlast,

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output      logic [31:0]       prdata,
	output      logic              pready
);

	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic             take_maximum_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             s1_valid_q;
	win_ctrl_t        ctrl_s1;
	pix_t             pix_s1;
	logic [COL_W-1:0] ic_s1;
	logic             bypass_s1;
	logic [STORE_W-1:0] fwd_s1;

	logic             out_valid_q;
	pix_t             out_data_q;
	logic             out_last_q;

	pix_t             win_q [3][3];

	logic             go;
	logic             s1_adv;
	logic             col_over;
	logic [COL_W-1:0] col_e;
	logic [ROW_W-1:0] row_e;
	logic             col_nz;
	logic             wrap;
	logic             pos_ok;
	logic             past_end;
	logic [DIM_W-1:0] col_ext;
	logic [ROW_W-1:0] cr;
	logic [DIM_W-1:0] cc;
	win_ctrl_t        ctrl_s0;

	logic [STORE_W-1:0] ram_rd;
	pix_t             upper_rd;
	pix_t             middle_rd;
	pix_t             cells [3][3];
	logic             use_cell [3][3];
	pix_t             result;

	// configuration port

	assign pready = 1'b1;
	assign w_eff  = clamp_dim(image_width_q, DIM_W'(MAX_WIDTH));
	assign h_eff  = clamp_dim(image_height_q, DIM_W'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_W'(1024);
			image_height_q <= DIM_W'(1024);
			take_maximum_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[DIM_W-1:0];
				REG_TAKE_MAXIMUM: take_maximum_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IMAGE_WIDTH:  prdata = 32'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(image_height_q);
			REG_TAKE_MAXIMUM: prdata = 32'(take_maximum_q);
			default:          prdata = '0;
		endcase
	end

	// raster position and window geometry of the incoming item

	assign s1_adv = s1_valid_q && (!ctrl_s1.emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign go = s_axis_tvalid && s_axis_tready
		&& !(s_axis_tuser && col_q == '0 && row_q == '0);

	// a column beyond a narrowed width moves to the start of the next row
	assign col_over = DIM_W'(col_q) >= w_eff;
	assign col_e    = col_over ? '0 : col_q;
	assign row_e    = col_over ? row_q + ROW_W'(1) : row_q;

	assign col_nz   = col_e != '0;
	assign col_ext  = DIM_W'(col_e);
	assign wrap     = (col_ext + DIM_W'(1)) >= w_eff;
	assign cr       = col_nz ? row_e - ROW_W'(1) : row_e - ROW_W'(2);
	assign cc       = col_nz ? col_ext - DIM_W'(1) : w_eff - DIM_W'(1);
	assign pos_ok   = (row_e > ROW_W'(1)) || (row_e == ROW_W'(1) && col_nz);
	assign past_end = pos_ok && (cr >= ROW_W'(h_eff));

	always_comb begin
		ctrl_s0.emit  = pos_ok && !past_end;
		ctrl_s0.last  = (row_e == ROW_W'(h_eff) + ROW_W'(1)) && !col_nz;
		ctrl_s0.up_ok = cr != '0;
		ctrl_s0.dn_ok = (cr + ROW_W'(1)) < ROW_W'(h_eff);
		ctrl_s0.lf_ok = cc != '0;
		ctrl_s0.rt_ok = (cc + DIM_W'(1)) < w_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (go) begin
			if (ctrl_s0.last || past_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_e + ROW_W'(1);
			end else begin
				col_q <= col_e + COL_W'(1);
				row_q <= row_e;
			end
		end
	end

	// line stores: upper row in the high half, middle row in the low half

	rmmwf_ram #(
		.WIDTH(STORE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (ic_s1),
		.wdata ({middle_rd, pix_s1}),
		.re    (go),
		.raddr (col_e),
		.rdata (ram_rd)
	);

	// single-column images read back the entry written in the same cycle
	assign upper_rd  = bypass_s1 ? fwd_s1[STORE_W-1:PIX_W] : ram_rd[STORE_W-1:PIX_W];
	assign middle_rd = bypass_s1 ? fwd_s1[PIX_W-1:0] : ram_rd[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			ctrl_s1    <= '0;
			bypass_s1  <= 1'b0;
		end else begin
			if (go) begin
				s1_valid_q <= 1'b1;
				ctrl_s1    <= ctrl_s0;
				bypass_s1  <= s1_adv && (col_e == ic_s1);
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
				bypass_s1  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			pix_s1 <= s_axis_tuser ? '0 : s_axis_tdata;
			ic_s1  <= col_e;
			fwd_s1 <= {middle_rd, pix_s1};
		end
	end

	// window after this item's shift

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			cells[r][0] = win_q[r][1];
			cells[r][1] = win_q[r][2];
		end
		cells[0][2] = upper_rd;
		cells[1][2] = middle_rd;
		cells[2][2] = pix_s1;
	end

	always_comb begin
		logic row_ok [3];
		logic col_ok [3];
		row_ok[0] = ctrl_s1.up_ok;
		row_ok[1] = 1'b1;
		row_ok[2] = ctrl_s1.dn_ok;
		col_ok[0] = ctrl_s1.lf_ok;
		col_ok[1] = 1'b1;
		col_ok[2] = ctrl_s1.rt_ok;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				use_cell[r][c] = row_ok[r] && col_ok[c];
			end
		end
	end

	always_comb begin
		logic [CH_W-1:0] best;
		logic [CH_W-1:0] v;
		result = '0;
		for (int ch = 0; ch < 3; ch++) begin
			best = take_maximum_q ? '0 : CH_MAX;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					v = cells[r][c][ch*CH_W +: CH_W];
					if (use_cell[r][c] && (take_maximum_q ? (v > best) : (v < best))) begin
						best = v;
					end
				end
			end
			result[ch*CH_W +: CH_W] = best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (s1_adv) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= cells[r][0];
				win_q[r][1] <= cells[r][1];
				win_q[r][2] <= cells[r][2];
			end
		end
	end

	// result register

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && ctrl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ctrl_s1.emit) begin
			out_data_q <= result;
			out_last_q <= ctrl_s1.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	ast_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctrl_s0.last) |=> (col_q == '0 && row_q == '0))
		else $error("position not rewound after last item of image");

	ast_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && ctrl_s1.emit && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while result stage is blocked");

	ast_bypass_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		bypass_s1 |-> s1_valid_q)
		else $error("line store bypass without an item in stage one");

	ast_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && ctrl_s1.emit) |=> out_valid_q)
		else $error("result lost on its way to the output register");
`endif

endmodule

`default_nettype wire

### design/rmmwf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rmmwf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
